>>> hdl/wavhc_pkg.sv
// ----------------------------------------------------------------------------
// wavhc_pkg
// Shared types and constants for the WAV header check and PCM gain block.
// ----------------------------------------------------------------------------
package wavhc_pkg;

  localparam logic [31:0] ID_RIFF = 32'h4646_4952;
  localparam logic [31:0] ID_WAVE = 32'h4556_4157;
  localparam logic [31:0] ID_FMT  = 32'h2074_6D66;
  localparam logic [31:0] ID_DATA = 32'h6174_6164;
  localparam logic [15:0] UNITY_PERCENT = 16'd100;

  typedef enum logic [3:0] {
    ST_PARSING   = 4'd0,
    ST_VALID     = 4'd1,
    ST_BAD_RIFF  = 4'd2,
    ST_SIZE_MISM = 4'd3,
    ST_BAD_WAVE  = 4'd4,
    ST_BAD_FMTID = 4'd5,
    ST_BAD_FMTSZ = 4'd6,
    ST_NOT_PCM   = 4'd7,
    ST_BAD_DATA  = 4'd8
  } status_t;

  localparam logic CFG_TOTAL_SIZE = 1'b0;
  localparam logic CFG_VOLUME     = 1'b1;

  // Work item handed from the front to the back end.
  typedef struct packed {
    logic        is_sample;  // scale sample_raw, else pass raw_byte
    logic        wide;       // 32-bit sample
    logic [31:0] sample_raw;
    logic [7:0]  raw_byte;
    logic [3:0]  status;
  } work_t;

endpackage

>>> hdl/wavhc_front.sv
// ----------------------------------------------------------------------------
// wavhc_front
// Header parser and sample gatherer: turns bytes into work items.
// ----------------------------------------------------------------------------
module wavhc_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic [7:0]              in_byte,
  input  logic [31:0]             total_size,
  input  logic [15:0]             volume_percent,
  output logic                    wk_valid,
  output wavhc_pkg::work_t        wk
);
  import wavhc_pkg::*;

  typedef enum logic [3:0] {
    PH_RIFF, PH_RSIZE, PH_WAVE, PH_FMTID, PH_FMTSZ, PH_BODY,
    PH_DATAID, PH_DSIZE, PH_DATA, PH_PASS
  } phase_t;

  phase_t      phase, phase_next;
  logic [31:0] pos;
  logic [3:0]  status, status_next;
  logic [31:0] gather, gather_next;
  logic [4:0]  fmt_len, fmt_len_next;
  logic [5:0]  swidth, swidth_next;
  logic [31:0] left, left_next;
  logic [31:0] sbuf, sbuf_next;
  logic [2:0]  scnt, scnt_next;
  logic        emit_s;
  logic [31:0] off;
  logic [2:0]  nb;
  logic        scale;
  logic [32:0] size_sum;

  assign nb    = swidth[5] ? 3'd4 : 3'd2;
  assign scale = (swidth != 6'd0) && (volume_percent != UNITY_PERCENT);
  assign off   = pos - 32'd20;

  // Parse step
  always_comb begin
    phase_next   = phase;
    status_next  = status;
    gather_next  = gather;
    fmt_len_next = fmt_len;
    swidth_next  = swidth;
    left_next    = left;
    sbuf_next    = sbuf;
    scnt_next    = scnt;
    emit_s       = 1'b0;
    size_sum     = {1'b0, gather_next} + 33'd8;
    if (phase < PH_DATA) begin
      gather_next = {in_byte, gather[31:8]};
    end
    size_sum = {1'b0, gather_next} + 33'd8;
    unique case (phase)
      PH_RIFF: if (pos == 32'd3) begin
        if (gather_next != ID_RIFF) begin
          status_next = ST_BAD_RIFF; phase_next = PH_PASS;
        end else phase_next = PH_RSIZE;
      end
      PH_RSIZE: if (pos == 32'd7) begin
        if (size_sum != {1'b0, total_size}) begin
          status_next = ST_SIZE_MISM; phase_next = PH_PASS;
        end else phase_next = PH_WAVE;
      end
      PH_WAVE: if (pos == 32'd11) begin
        if (gather_next != ID_WAVE) begin
          status_next = ST_BAD_WAVE; phase_next = PH_PASS;
        end else phase_next = PH_FMTID;
      end
      PH_FMTID: if (pos == 32'd15) begin
        if (gather_next != ID_FMT) begin
          status_next = ST_BAD_FMTID; phase_next = PH_PASS;
        end else phase_next = PH_FMTSZ;
      end
      PH_FMTSZ: if (pos == 32'd19) begin
        if (gather_next == 32'd16 || gather_next == 32'd18) begin
          fmt_len_next = gather_next[4:0];
          phase_next   = PH_BODY;
        end else begin
          status_next = ST_BAD_FMTSZ; phase_next = PH_PASS;
        end
      end
      PH_BODY: begin
        if (off == 32'd1 && gather_next[31:16] != 16'd1) begin
          status_next = ST_NOT_PCM; phase_next = PH_PASS;
        end else begin
          if (off == 32'd15) begin
            swidth_next = (gather_next[31:16] == 16'd16 || gather_next[31:16] == 16'd32)
                          ? gather_next[21:16] : 6'd0;
          end
          if (off + 32'd1 == {27'd0, fmt_len}) phase_next = PH_DATAID;
        end
      end
      PH_DATAID: if (pos == 32'd23 + {27'd0, fmt_len}) begin
        if (gather_next != ID_DATA) begin
          status_next = ST_BAD_DATA; phase_next = PH_PASS;
        end else begin
          status_next = ST_VALID; phase_next = PH_DSIZE;
        end
      end
      PH_DSIZE: if (pos == 32'd27 + {27'd0, fmt_len}) begin
        left_next  = gather_next;
        phase_next = (gather_next != 32'd0) ? PH_DATA : PH_PASS;
      end
      PH_DATA: begin
        left_next = left - 32'd1;
        if (scale && !(scnt == 3'd0 && left < {29'd0, nb})) begin
          sbuf_next = {in_byte, sbuf[31:8]};
          scnt_next = scnt + 3'd1;
          if (scnt + 3'd1 == nb) begin
            scnt_next = 3'd0;
            emit_s    = 1'b1;
          end
        end
        if (left_next == 32'd0) phase_next = PH_PASS;
      end
      default: phase_next = PH_PASS;
    endcase
  end

  // State registers and work item
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_RIFF;
      pos      <= '0;
      status   <= ST_PARSING;
      gather   <= '0;
      fmt_len  <= '0;
      swidth   <= '0;
      left     <= '0;
      sbuf     <= '0;
      scnt     <= '0;
      wk_valid <= 1'b0;
    end else begin
      wk_valid <= 1'b0;
      if (in_valid) begin
        phase    <= phase_next;
        if (pos != 32'hFFFF_FFFF) pos <= pos + 32'd1;
        status   <= status_next;
        gather   <= gather_next;
        fmt_len  <= fmt_len_next;
        swidth   <= swidth_next;
        left     <= left_next;
        sbuf     <= sbuf_next;
        scnt     <= scnt_next;
        // a gathering beat without completion produces nothing
        wk_valid <= emit_s || !(phase == PH_DATA && scale &&
                     !(scnt == 3'd0 && left < {29'd0, nb}));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      wk.is_sample  <= emit_s;
      wk.wide       <= swidth[5];
      wk.sample_raw <= sbuf_next;
      wk.raw_byte   <= in_byte;
      wk.status     <= status_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PASS) |=> (phase == PH_PASS))
    else $error("left pass-through phase");
  assert property (@(posedge clk) disable iff (rst)
    (status != ST_PARSING && status != ST_VALID) |=> $stable(status))
    else $error("error status changed");
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && emit_s) |=> wk_valid)
    else $error("sample completion lost");
endmodule

>>> hdl/wavhc_fifo.sv
// ----------------------------------------------------------------------------
// wavhc_fifo
// Small work queue between front and back end.
// ----------------------------------------------------------------------------
module wavhc_fifo #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  wavhc_pkg::work_t wdata,
  input  logic             rd,
  output logic             nonempty,
  output logic [$clog2(DEPTH+1)-1:0] count,
  output wavhc_pkg::work_t rdata
);
  import wavhc_pkg::*;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  work_t          mem [DEPTH];
  logic [AW-1:0]  wp, rp;

  assign nonempty = (count != '0);
  assign rdata    = mem[rp];

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; count <= '0;
    end else begin
      if (wr) wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      if (rd) rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      count <= count + (wr ? 1'b1 : 1'b0) - (rd ? 1'b1 : 1'b0);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wdata;
  end

  assert property (@(posedge clk) disable iff (rst)
    !(wr && !rd && count == ($clog2(DEPTH+1))'(DEPTH)))
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (rst) !(rd && count == '0))
    else $error("queue underflow");
  assert property (@(posedge clk) disable iff (rst)
    (wr && !rd) |=> (count == $past(count) + 1'b1))
    else $error("count not advanced");
endmodule

>>> hdl/wavhc_back.sv
// ----------------------------------------------------------------------------
// wavhc_back
// Scales samples by percent/100 with saturation; serializes them and raw bytes.
// ----------------------------------------------------------------------------
module wavhc_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_nonempty,
  input  wavhc_pkg::work_t q_data,
  output logic             q_rd,
  input  logic [15:0]      volume_percent,
  output logic             empty,
  input  logic             pop,
  output logic [7:0]       out_byte,
  output logic             out_last,
  output logic [3:0]       parse_status
);
  import wavhc_pkg::*;

  // stage 1: product; stage 2: upper quotient digit of x/100; stage 3: lower
  // digit, saturation and output.
  // x = xh*2^24 + xl, xh = 100*qh + rh, so x/100 = qh*2^24 + (rh*2^24 + xl)/100.
  // Each partial divide is floor(z*RECIP/2^37), exact for z < 2^32.
  localparam logic [30:0] RECIP = 31'd1374389535; // ceil(2^37/100)

  logic        s1_v, s2_v, s3_v;
  logic        s1_wide, s2_wide;
  logic        s1_samp, s2_samp;
  logic [7:0]  s1_raw, s2_raw;
  logic [3:0]  s1_st, s2_st;
  logic        s1_neg, s2_neg;
  logic [47:0] s1_mag;          // |s| * percent, < 2^47
  logic [17:0] s2_qh;
  logic [6:0]  s2_rh;
  logic [23:0] s2_xl;
  logic [31:0] s3_word;
  logic [2:0]  s3_left, s3_idx;
  logic        s3_wide;
  logic [3:0]  s3_st;
  logic        adv;
  logic [31:0] s_val, s_abs;
  logic        neg_in;
  logic [23:0] xh;
  logic [54:0] hprod;
  logic [17:0] qh;
  logic [23:0] rh_full;
  logic [30:0] zlo;
  logic [61:0] lprod;
  logic [23:0] ql;
  logic [47:0] quo;
  logic [48:0] sv;
  logic [31:0] sat;

  // pipeline moves when output stage can take a new item
  assign adv  = !s3_v || (pop && s3_left == 3'd1);
  assign q_rd = q_nonempty && adv;

  assign s_val  = q_data.wide ? q_data.sample_raw : {{16{q_data.sample_raw[31]}},
                                                     q_data.sample_raw[31:16]};
  assign neg_in = s_val[31];
  assign s_abs  = neg_in ? (32'd0 - s_val) : s_val;

  // Stage 1: magnitude times percent
  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0;
    else if (adv) s1_v <= q_rd;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_wide <= q_data.wide;
      s1_samp <= q_data.is_sample;
      s1_raw  <= q_data.raw_byte;
      s1_st   <= q_data.status;
      s1_neg  <= neg_in;
      s1_mag  <= 48'(s_abs) * 48'(volume_percent);
    end
  end

  // Stage 2: upper quotient digit and its remainder
  assign xh      = s1_mag[47:24];
  assign hprod   = 55'(xh) * 55'(RECIP);
  assign qh      = hprod[54:37];
  assign rh_full = xh - 24'(qh * 18'd100);

  always_ff @(posedge clk) begin
    if (rst) s2_v <= 1'b0;
    else if (adv) s2_v <= s1_v;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_wide <= s1_wide; s2_samp <= s1_samp; s2_raw <= s1_raw;
      s2_st <= s1_st; s2_neg <= s1_neg;
      s2_qh <= qh; s2_rh <= rh_full[6:0]; s2_xl <= s1_mag[23:0];
    end
  end

  // Lower quotient digit
  assign zlo   = {s2_rh, s2_xl};
  assign lprod = 62'(zlo) * 62'(RECIP);
  assign ql    = lprod[60:37];
  assign quo   = {6'd0, s2_qh, ql};

  // Saturation of signed quotient
  always_comb begin
    sv = s2_neg ? (49'd0 - {1'b0, quo}) : {1'b0, quo};
    if (s2_wide) begin
      if (!s2_neg && quo > 48'h7FFF_FFFF)       sat = 32'h7FFF_FFFF;
      else if (s2_neg && quo > 48'h8000_0000)   sat = 32'h8000_0000;
      else                                      sat = sv[31:0];
    end else begin
      if (!s2_neg && quo > 48'h7FFF)            sat = 32'h0000_7FFF;
      else if (s2_neg && quo > 48'h8000)        sat = 32'h0000_8000;
      else                                      sat = {16'd0, sv[15:0]};
    end
  end

  // Stage 3: byte serializer
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0; s3_left <= '0; s3_idx <= '0;
    end else if (adv) begin
      s3_v    <= s2_v;
      s3_idx  <= '0;
      s3_left <= !s2_samp ? 3'd1 : (s2_wide ? 3'd4 : 3'd2);
    end else if (pop && s3_v) begin
      s3_left <= s3_left - 3'd1;
      s3_idx  <= s3_idx + 3'd1;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s3_word <= s2_samp ? sat : {24'd0, s2_raw};
      s3_wide <= s2_wide;
      s3_st   <= s2_st;
    end
  end

  assign empty        = !s3_v;
  assign out_byte     = s3_word[8*s3_idx[1:0] +: 8];
  assign out_last     = (s3_left == 3'd1);
  assign parse_status = s3_st;

  assert property (@(posedge clk) disable iff (rst) s3_v |-> (s3_left != 3'd0))
    else $error("empty run on output");
  assert property (@(posedge clk) disable iff (rst)
    (s3_v && !s3_wide) |-> (s3_idx < 3'd2))
    else $error("short sample overrun");
  assert property (@(posedge clk) disable iff (rst)
    (pop && s3_v && !out_last) |=> s3_v)
    else $error("run cut short");
endmodule

>>> hdl/wav_header_check_pcm_gain.sv
// ----------------------------------------------------------------------------
// wav_header_check_pcm_gain
// WAV header check with PCM volume scaling, one byte per beat.
// Path: a byte goes via the front work register, queue and back stages 1 to 3.
// Throughput: one byte per cycle in while full is low; a scaled sample
// leaves 2 or 4 bytes, one per cycle while popped, set by the serializer.
// Reset: rst synchronous, clears parser, queue and pipeline; volume 100.
// ----------------------------------------------------------------------------
module wav_header_check_pcm_gain (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic [3:0]  parse_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);
  import wavhc_pkg::*;

  logic [31:0] total_size;
  logic [15:0] volume_percent;
  logic        wk_valid, q_ne, q_rd, acc;
  work_t       wk, q_data;
  logic [3:0]  q_cnt;

  assign cfg_ready = 1'b1;
  // room for this beat plus the one in flight in the front end's work register
  assign full = (q_cnt >= 4'd6);
  assign acc  = push && !full;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      total_size     <= '0;
      volume_percent <= UNITY_PERCENT;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TOTAL_SIZE: total_size     <= cfg_data;
        CFG_VOLUME:     volume_percent <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  wavhc_front u_front (
    .clk, .rst, .in_valid(acc), .in_byte, .total_size, .volume_percent,
    .wk_valid, .wk
  );

  wavhc_fifo #(.DEPTH(8)) u_fifo (
    .clk, .rst, .wr(wk_valid), .wdata(wk), .rd(q_rd),
    .nonempty(q_ne), .count(q_cnt), .rdata(q_data)
  );

  wavhc_back u_back (
    .clk, .rst, .q_nonempty(q_ne), .q_data, .q_rd, .volume_percent,
    .empty, .pop, .out_byte, .out_last, .parse_status
  );

  assert property (@(posedge clk) disable iff (rst) acc |=> !$past(full))
    else $error("accepted while full");
endmodule
